// File: hdl/kruskal_union_find_merger_unit_assert.svh
// Assertion macros for the union-find merger unit.
// Included by the top level; needs nothing else.
`ifndef KRUSKAL_UNION_FIND_MERGER_UNIT_ASSERT_SVH
`define KRUSKAL_UNION_FIND_MERGER_UNIT_ASSERT_SVH

// same-cycle implication
`define UFM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UFM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ufm_pkg.sv
// Shared types and constants for the union-find merger unit.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package ufm_pkg;

  localparam int NODE_W = 10;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 1;

  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [IDX_W-1:0] REG_NODE_COUNT     = 1'b0;
  localparam logic [IDX_W-1:0] REG_CLUSTER_TARGET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_F1_RD,
    ST_F1_CHK,
    ST_F2_RD,
    ST_F2_CHK,
    ST_LINK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              accepted;
    logic [NODE_W-1:0] merge_index;
    logic              keep;
    logic              done_res;
  } res_t;

endpackage

// File: hdl/ufm_edge_if.sv
// Edge channel: valid/ready handshake with opcode and two endpoints.
// Depends on ufm_pkg for field widths.
`timescale 1ns / 1ps

interface ufm_edge_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [ufm_pkg::NODE_W-1:0] node_a;
  logic [ufm_pkg::NODE_W-1:0] node_b;

  modport source (output valid, output opcode, output node_a, output node_b, input ready);
  modport sink   (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

// File: hdl/ufm_result_if.sv
// Result channel: valid/ready handshake with one result word per edge.
// Depends on ufm_pkg for field widths.
`timescale 1ns / 1ps

interface ufm_result_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [ufm_pkg::NODE_W-1:0] merge_index;
  logic                       keep;
  logic                       done_res;

  modport source (output valid, output accepted, output merge_index, output keep,
                  output done_res, input ready);
  modport sink   (input valid, input accepted, input merge_index, input keep,
                  input done_res, output ready);
endinterface

// File: hdl/ufm_parent_ram.sv
// Parent table storage: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module ufm_parent_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ufm_engine.sv
// Find/link sequencer: walks parent chains through one table read port, compresses
// paths, links roots and builds the result word. Depends on ufm_pkg, ufm_parent_ram.
`timescale 1ns / 1ps

module ufm_engine #(
  parameter int MAX_NODES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       opcode,
  input  logic [ufm_pkg::NODE_W-1:0] node_a,
  input  logic [ufm_pkg::NODE_W-1:0] node_b,
  input  logic [ufm_pkg::CFG_W-1:0]  node_count,
  input  logic [ufm_pkg::CFG_W-1:0]  cluster_target,
  output logic                       in_ready,
  output logic                       res_valid,
  output ufm_pkg::res_t              res,
  input  logic                       res_ready
);

  localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW_M = $clog2(MAX_NODES + 1);
  localparam int CW   = (CW_M > ufm_pkg::CFG_W) ? CW_M : ufm_pkg::CFG_W;
  localparam logic [NW-1:0] LAST_ENTRY = NW'(MAX_NODES - 1);
  localparam logic [CW-1:0] MAX_CNT    = CW'(MAX_NODES);

  ufm_pkg::state_t state, state_next;
  logic [NW-1:0] clr_idx, clr_idx_next;
  logic          clr_reply, clr_reply_next;
  logic          second, second_next;
  logic [NW-1:0] start_node, start_node_next;
  logic [NW-1:0] b_node, b_node_next;
  logic [NW-1:0] root, root_next;
  logic [NW-1:0] cur, cur_next;
  logic [NW-1:0] ra, ra_next;
  logic [CW-1:0] merge_count, merge_count_next;
  logic          finished, finished_next;
  ufm_pkg::res_t res_next;

  logic          we;
  logic [NW-1:0] waddr, wdata, raddr, rdata;

  logic [CW-1:0] nc_ext, kc_ext, n_eff, k_eff, n_m1, count_inc;
  logic          fin_link, keep_link;

  ufm_parent_ram #(.DEPTH(MAX_NODES), .AW(NW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // clamp the configured counts to their usable range
  always_comb begin
    nc_ext = CW'(node_count);
    kc_ext = CW'(cluster_target);
    if (nc_ext == '0) begin
      n_eff = CW'(1);
    end else if (nc_ext > MAX_CNT) begin
      n_eff = MAX_CNT;
    end else begin
      n_eff = nc_ext;
    end
    k_eff     = (kc_ext == '0) ? CW'(1) : kc_ext;
    n_m1      = n_eff - CW'(1);
    count_inc = merge_count + CW'(1);
    fin_link  = (count_inc >= n_m1);
    keep_link = (k_eff <= n_eff) && (merge_count < (n_eff - k_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ufm_pkg::ST_CLEAR;
      clr_idx     <= '0;
      clr_reply   <= 1'b0;
      merge_count <= '0;
      finished    <= 1'b0;
    end else begin
      state       <= state_next;
      clr_idx     <= clr_idx_next;
      clr_reply   <= clr_reply_next;
      merge_count <= merge_count_next;
      finished    <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    second     <= second_next;
    start_node <= start_node_next;
    b_node     <= b_node_next;
    root       <= root_next;
    cur        <= cur_next;
    ra         <= ra_next;
    res        <= res_next;
  end

  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    clr_reply_next   = clr_reply;
    second_next      = second;
    start_node_next  = start_node;
    b_node_next      = b_node;
    root_next        = root;
    cur_next         = cur;
    ra_next          = ra;
    merge_count_next = merge_count;
    finished_next    = finished;
    res_next         = res;
    we               = 1'b0;
    waddr            = cur;
    wdata            = root;
    raddr            = root;
    in_ready         = 1'b0;
    res_valid        = 1'b0;

    case (state)
      ufm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          if (opcode == ufm_pkg::OP_RESTART) begin
            merge_count_next = '0;
            finished_next    = 1'b0;
            res_next         = '0;
            clr_reply_next   = 1'b1;
            clr_idx_next     = '0;
            state_next       = ufm_pkg::ST_CLEAR;
          end else if (finished || (merge_count >= n_m1)) begin
            finished_next     = 1'b1;
            res_next          = '0;
            res_next.done_res = 1'b1;
            state_next        = ufm_pkg::ST_OUT;
          end else if ((CW'(node_a) >= n_eff) || (CW'(node_b) >= n_eff)) begin
            res_next   = '0;
            state_next = ufm_pkg::ST_OUT;
          end else begin
            start_node_next = NW'(node_a);
            root_next       = NW'(node_a);
            b_node_next     = NW'(node_b);
            second_next     = 1'b0;
            state_next      = ufm_pkg::ST_F1_RD;
          end
        end
      end

      ufm_pkg::ST_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_idx;
        wdata        = clr_idx;
        clr_idx_next = clr_idx + NW'(1);
        if (clr_idx == LAST_ENTRY) begin
          state_next = clr_reply ? ufm_pkg::ST_OUT : ufm_pkg::ST_IDLE;
        end
      end

      ufm_pkg::ST_F1_RD: begin
        raddr      = root;
        state_next = ufm_pkg::ST_F1_CHK;
      end

      ufm_pkg::ST_F1_CHK: begin
        if (rdata == root) begin
          cur_next   = start_node;
          state_next = ufm_pkg::ST_F2_RD;
        end else begin
          root_next  = rdata;
          state_next = ufm_pkg::ST_F1_RD;
        end
      end

      ufm_pkg::ST_F2_RD: begin
        raddr = cur;
        if (cur == root) begin
          if (!second) begin
            // first root found: start on the second endpoint
            ra_next         = root;
            second_next     = 1'b1;
            start_node_next = b_node;
            root_next       = b_node;
            state_next      = ufm_pkg::ST_F1_RD;
          end else begin
            state_next = ufm_pkg::ST_LINK;
          end
        end else begin
          state_next = ufm_pkg::ST_F2_CHK;
        end
      end

      ufm_pkg::ST_F2_CHK: begin
        // point this node at the root, advance along the old parent
        we         = 1'b1;
        waddr      = cur;
        wdata      = root;
        cur_next   = rdata;
        state_next = ufm_pkg::ST_F2_RD;
      end

      ufm_pkg::ST_LINK: begin
        if (ra == root) begin
          res_next = '0;
        end else begin
          we = 1'b1;
          if (ra < root) begin
            waddr = root;
            wdata = ra;
          end else begin
            waddr = ra;
            wdata = root;
          end
          merge_count_next     = count_inc;
          finished_next        = fin_link;
          res_next.accepted    = 1'b1;
          res_next.merge_index = merge_count[ufm_pkg::NODE_W-1:0];
          res_next.keep        = keep_link;
          res_next.done_res    = fin_link;
        end
        state_next = ufm_pkg::ST_OUT;
      end

      ufm_pkg::ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ufm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ufm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/kruskal_union_find_merger_unit.sv
// Top level of the union-find merger: configuration registers, result register,
// and the find/link engine. Depends on ufm_pkg, the channel interfaces, ufm_engine.
//
//   channel   dir   word
//   edges     in    opcode, node_a, node_b
//   results   out   accepted, merge_index, keep, done_res
//   cfg_*     in    write enable, register index, 11-bit data
//
// A table probe sends the address, then uses the registered read data, on the
// parent table's single read port. An edge's work grows with the chain lengths La
// and Lb to its two roots; compression keeps these short.
// Reset and restart clear all MAX_NODES table entries with edges held off;
// a restart word returns once its pass ends. Results wait in an output register,
// so the next edge is taken while a result is stalled.
`timescale 1ns / 1ps

`include "kruskal_union_find_merger_unit_assert.svh"

module kruskal_union_find_merger_unit #(
  parameter int MAX_NODES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  ufm_edge_if.sink                   edges,
  ufm_result_if.source               results,
  input  logic                       cfg_wr_en,
  input  logic [ufm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ufm_pkg::CFG_W-1:0]  cfg_data
);

  logic [ufm_pkg::CFG_W-1:0] node_count;
  logic [ufm_pkg::CFG_W-1:0] cluster_target;
  logic                      in_ready;
  logic                      res_valid;
  logic                      res_ready;
  ufm_pkg::res_t             res;
  logic                      out_valid;
  ufm_pkg::res_t             out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count     <= 11'd1024;
      cluster_target <= 11'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ufm_pkg::REG_NODE_COUNT:     node_count     <= cfg_data;
        ufm_pkg::REG_CLUSTER_TARGET: cluster_target <= cfg_data;
        default: ;
      endcase
    end
  end

  ufm_engine #(.MAX_NODES(MAX_NODES)) u_engine (
    .clk            (clk),
    .rst            (rst),
    .start          (edges.valid && in_ready),
    .opcode         (edges.opcode),
    .node_a         (edges.node_a),
    .node_b         (edges.node_b),
    .node_count     (node_count),
    .cluster_target (cluster_target),
    .in_ready       (in_ready),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  assign edges.ready = in_ready;

  // output register: load when empty or being drained
  assign res_ready = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign results.valid       = out_valid;
  assign results.accepted    = out_word.accepted;
  assign results.merge_index = out_word.merge_index;
  assign results.keep        = out_word.keep;
  assign results.done_res    = out_word.done_res;

  `UFM_ASSERT_NXT(a_busy_after_accept, clk, rst, edges.valid && edges.ready, !edges.ready, "engine took a second word back to back")
  `UFM_ASSERT_IMP(a_reject_clean, clk, rst, out_valid && !out_word.accepted, (out_word.merge_index == '0) && !out_word.keep, "rejected word carries merge data")
  `UFM_ASSERT_IMP(a_keep_needs_merge, clk, rst, out_valid && out_word.keep, out_word.accepted, "keep flagged on an edge that did not merge")

endmodule
